@@ rtl/core/rwla_pkg.sv @@
// Package for the reader/writer lock arbiter: sizes, command codes and the
// command and result records passed between the front and back ends.
// No dependencies.
`timescale 1ns / 1ps

package rwla_pkg;

  localparam int unsigned IdW        = 4;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned FillW      = $clog2(QueueDepth + 1);
  localparam int unsigned CountW     = 5;
  localparam int unsigned CountMax   = (1 << CountW) - 1;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned BurstW     = $clog2(MaxResults + 1);
  localparam int unsigned CmdDepth   = 2;

  typedef enum logic [1:0] {
    FuncStartRead  = 2'd0,
    FuncEndRead    = 2'd1,
    FuncStartWrite = 2'd2,
    FuncEndWrite   = 2'd3
  } func_e;

  typedef struct packed {
    func_e            func;
    logic [IdW-1:0]   id;
  } cmd_t;

  typedef struct packed {
    logic [IdW-1:0]    grant_id;
    logic              grant_is_write;
    logic              refused;
    logic [CountW-1:0] readers_active;
    logic              last;
  } result_t;

endpackage

@@ rtl/core/rwla_wait_queue.sv @@
// Circular wait queue of requester ids with a fill count.
// Depends on rwla_pkg.
`timescale 1ns / 1ps

module rwla_wait_queue
  import rwla_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [IdW-1:0]   push_id_i,
  input  logic             pop_i,
  output logic [IdW-1:0]   head_id_o,
  output logic [FillW-1:0] fill_o,
  output logic             full_o
);

  logic [IdW-1:0]   mem_q [QueueDepth];
  logic [QPtrW-1:0] head_q, head_d;
  logic [QPtrW-1:0] tail_q, tail_d;
  logic [FillW-1:0] fill_q, fill_d;

  function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] p);
    if (p == QPtrW'(QueueDepth - 1)) begin
      return '0;
    end
    return p + QPtrW'(1);
  endfunction

  always_comb begin
    head_d = pop_i ? ptr_next(head_q) : head_q;
    tail_d = push_i ? ptr_next(tail_q) : tail_q;
    fill_d = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + FillW'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= push_id_i;
    end
  end

  assign head_id_o = mem_q[head_q];
  assign fill_o    = fill_q;
  assign full_o    = (fill_q == FillW'(QueueDepth));

endmodule

@@ rtl/core/rwla_front.sv @@
// Front end: takes requests from the input stream, decodes the command and
// holds them in a short command queue for the back end. Depends on rwla_pkg.
`timescale 1ns / 1ps

module rwla_front
  import rwla_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     in_func_i,
  input  logic [IdW-1:0] in_id_i,
  output logic           cmd_valid_o,
  output cmd_t           cmd_o,
  input  logic           cmd_take_i
);

  localparam int unsigned CPtrW = $clog2(CmdDepth);
  localparam int unsigned CCntW = $clog2(CmdDepth + 1);

  cmd_t             buf_q [CmdDepth];
  logic [CPtrW-1:0] rd_q, rd_d;
  logic [CPtrW-1:0] wr_q, wr_d;
  logic [CCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;
  cmd_t             in_cmd;

  function automatic logic [CPtrW-1:0] cptr_next(input logic [CPtrW-1:0] p);
    if (p == CPtrW'(CmdDepth - 1)) begin
      return '0;
    end
    return p + CPtrW'(1);
  endfunction

  assign in_ready_o  = (cnt_q != CCntW'(CmdDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_take_i && cmd_valid_o;
  assign cmd_o       = buf_q[rd_q];

  always_comb begin
    in_cmd.func = func_e'(in_func_i);
    in_cmd.id   = in_id_i;
  end

  always_comb begin
    rd_d  = pop ? cptr_next(rd_q) : rd_q;
    wr_d  = push ? cptr_next(wr_q) : wr_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= in_cmd;
    end
  end

endmodule

@@ rtl/core/rwla_back.sv @@
// Back end: lock state, the reader and writer wait queues, the grant
// sequencer and the output register. Depends on rwla_pkg, rwla_wait_queue.
`timescale 1ns / 1ps

module rwla_back
  import rwla_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_take_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  localparam logic StIdle  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic              state_q, state_d;
  logic              writer_active_q, writer_active_d;
  logic [CountW-1:0] reader_count_q, reader_count_d;
  logic [BurstW-1:0] burst_q, burst_d;
  logic [BurstW-1:0] burst_inc;
  logic [CountW-1:0] count_inc;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;
  logic              slot_free;
  logic              emit;
  result_t           item;

  logic              rq_push, rq_pop, rq_full;
  logic [IdW-1:0]    rq_head;
  logic [FillW-1:0]  rq_fill;
  logic              wq_push, wq_pop, wq_full;
  logic [IdW-1:0]    wq_head;
  logic [FillW-1:0]  wq_fill;

  rwla_wait_queue u_reader_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (rq_push),
    .push_id_i (cmd_i.id),
    .pop_i     (rq_pop),
    .head_id_o (rq_head),
    .fill_o    (rq_fill),
    .full_o    (rq_full)
  );

  rwla_wait_queue u_writer_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (wq_push),
    .push_id_i (cmd_i.id),
    .pop_i     (wq_pop),
    .head_id_o (wq_head),
    .fill_o    (wq_fill),
    .full_o    (wq_full)
  );

  // The output register is free when empty or being emptied this cycle.
  assign slot_free = !out_valid_q || out_ready_i;
  assign count_inc = (reader_count_q == CountW'(CountMax)) ? reader_count_q
                                                           : reader_count_q + CountW'(1);
  assign burst_inc = burst_q + BurstW'(1);

  always_comb begin
    state_d         = state_q;
    writer_active_d = writer_active_q;
    reader_count_d  = reader_count_q;
    burst_d         = burst_q;
    cmd_take_o      = 1'b0;
    rq_push         = 1'b0;
    rq_pop          = 1'b0;
    wq_push         = 1'b0;
    wq_pop          = 1'b0;
    emit            = 1'b0;
    item            = '{grant_id: cmd_i.id, grant_is_write: 1'b0, refused: 1'b0,
                        readers_active: reader_count_q, last: 1'b1};

    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i && slot_free) begin
          cmd_take_o = 1'b1;
          unique case (cmd_i.func)
            FuncStartRead: begin
              if (writer_active_q) begin
                if (rq_full) begin
                  emit         = 1'b1;
                  item.refused = 1'b1;
                end else begin
                  rq_push = 1'b1;
                end
              end else begin
                // Grant the requester, then hand on to any queued readers.
                reader_count_d      = count_inc;
                emit                = 1'b1;
                item.readers_active = count_inc;
                item.last           = (rq_fill == '0);
                if (rq_fill != '0) begin
                  state_d = StDrain;
                  burst_d = BurstW'(1);
                end
              end
            end
            FuncEndRead: begin
              if (reader_count_q != '0) begin
                reader_count_d = reader_count_q - CountW'(1);
                if (reader_count_q == CountW'(1) && !writer_active_q && wq_fill != '0) begin
                  wq_pop              = 1'b1;
                  writer_active_d     = 1'b1;
                  emit                = 1'b1;
                  item.grant_id       = wq_head;
                  item.grant_is_write = 1'b1;
                  item.readers_active = '0;
                end
              end
            end
            FuncStartWrite: begin
              item.grant_is_write = 1'b1;
              if (writer_active_q || reader_count_q != '0) begin
                if (wq_full) begin
                  emit         = 1'b1;
                  item.refused = 1'b1;
                end else begin
                  wq_push = 1'b1;
                end
              end else begin
                writer_active_d = 1'b1;
                emit            = 1'b1;
              end
            end
            FuncEndWrite: begin
              if (writer_active_q) begin
                writer_active_d = 1'b0;
                if (rq_fill != '0) begin
                  state_d = StDrain;
                  burst_d = '0;
                end else if (wq_fill != '0) begin
                  wq_pop              = 1'b1;
                  writer_active_d     = 1'b1;
                  emit                = 1'b1;
                  item.grant_id       = wq_head;
                  item.grant_is_write = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      StDrain: begin
        // One queued reader is granted per cycle while the output register is free, until the queue
        // is empty or the burst reaches its limit; the rest wait for a read grant or a write release.
        if (slot_free) begin
          rq_pop              = 1'b1;
          reader_count_d      = count_inc;
          burst_d             = burst_inc;
          emit                = 1'b1;
          item.grant_id       = rq_head;
          item.readers_active = count_inc;
          item.last           = (rq_fill == FillW'(1)) || (burst_inc == BurstW'(MaxResults));
          if (item.last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = item;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      writer_active_q <= 1'b0;
      reader_count_q  <= '0;
      burst_q         <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      writer_active_q <= writer_active_d;
      reader_count_q  <= reader_count_d;
      burst_q         <= burst_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ rtl/core/reader_writer_lock_arbiter.sv @@
// Reader-priority readers/writer lock arbiter with FIFO wait queues.
// Requests wait in the front command queue, then the back end registers their results.
// Throughput: the back end executes one command per cycle while the output is accepted and
// no burst is running; a reader burst grants its queued readers one by one through the single
// reader-queue pop port (a writer release that finds readers queued grants nothing itself; they follow it).
// Reset: asynchronous, active low; lock free, all queues and the output empty.
`timescale 1ns / 1ps

module reader_writer_lock_arbiter
  import rwla_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] requester, [7:4] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [3:0] grant_id, [8:4] readers_active, [15:9] zero
  output logic [1:0]  m_axis_tuser,   // [0] grant_is_write, [1] refused
  output logic        m_axis_tlast
);

  logic    cmd_valid;
  logic    cmd_take;
  cmd_t    cmd;
  result_t res;

  rwla_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_func_i   (s_axis_tuser),
    .in_id_i     (s_axis_tdata[IdW-1:0]),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  rwla_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {7'd0, res.readers_active, res.grant_id};
  assign m_axis_tuser = {res.refused, res.grant_is_write};
  assign m_axis_tlast = res.last;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for the reader/writer lock arbiter: a queue-fed request
// driver, a result monitor and a cycle-free model of the lock in SystemVerilog.
// Depends on rwla_pkg and reader_writer_lock_arbiter.
`timescale 1ns / 1ps

module tb;
  import rwla_pkg::*;

  typedef struct {
    func_e          func;
    logic [IdW-1:0] id;
    bit             hold;   // wait for every outstanding grant before offering
    bit             quiet;  // start no new idling on either side while this is in flight
  } lock_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [3:0] requester, [7:4] zero
  logic [1:0]  s_axis_tuser = '0;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [3:0] grant_id, [8:4] readers_active, [15:9] zero
  logic [1:0]  m_axis_tuser;        // [0] grant_is_write, [1] refused
  logic        m_axis_tlast;

  lock_req_t   pending[$];
  lock_req_t   in_flight;
  result_t     grant_q[$];          // grants and refusals still owed by the block
  result_t     burst[$];
  result_t     want;
  int          gap_left;
  int          stall_left;
  int          mismatches;
  bit          quiet_now;
  bit          quiet_seq;
  logic        offer;

  // Lock state as the block should hold it.
  logic              wr_held;
  logic [CountW-1:0] rd_count;
  logic [IdW-1:0]    rd_wait[$];
  logic [IdW-1:0]    wr_wait[$];

  reader_writer_lock_arbiter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t grant_rec(logic [IdW-1:0] id, logic wr, logic refused_b);
    result_t r;
    r.grant_id       = id;
    r.grant_is_write = wr;
    r.refused        = refused_b;
    r.readers_active = rd_count;
    r.last           = 1'b0;
    return r;
  endfunction

  function automatic void admit_reader();
    if (rd_count != CountMax) rd_count++;
  endfunction

  function automatic void wake_readers();
    while (rd_wait.size() > 0 && burst.size() < MaxResults) begin
      admit_reader();
      burst.push_back(grant_rec(rd_wait.pop_front(), 1'b0, 1'b0));
    end
  endfunction

  function automatic void wake_writer();
    if (wr_wait.size() > 0 && burst.size() < MaxResults) begin
      wr_held = 1'b1;
      burst.push_back(grant_rec(wr_wait.pop_front(), 1'b1, 1'b0));
    end
  endfunction

  // Applies one accepted request to the lock and queues the grants and refusals it causes.
  function automatic void arbitrate(func_e f, logic [IdW-1:0] id);
    burst.delete();
    case (f)
      FuncStartRead: begin
        if (wr_held) begin
          if (rd_wait.size() < QueueDepth) rd_wait.push_back(id);
          else burst.push_back(grant_rec(id, 1'b0, 1'b1));
        end else begin
          admit_reader();
          burst.push_back(grant_rec(id, 1'b0, 1'b0));
          wake_readers();
        end
      end
      FuncEndRead: begin
        if (rd_count != 0) begin
          rd_count--;
          if (rd_count == 0 && !wr_held) wake_writer();
        end
      end
      FuncStartWrite: begin
        if (wr_held || rd_count != 0) begin
          if (wr_wait.size() < QueueDepth) wr_wait.push_back(id);
          else burst.push_back(grant_rec(id, 1'b1, 1'b1));
        end else begin
          wr_held = 1'b1;
          burst.push_back(grant_rec(id, 1'b1, 1'b0));
        end
      end
      default: begin
        if (wr_held) begin
          wr_held = 1'b0;
          if (rd_wait.size() > 0) wake_readers();
          else wake_writer();
        end
      end
    endcase
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) grant_q.push_back(burst[i]);
  endfunction

  function automatic void add(func_e f, int id);
    lock_req_t r;
    r.func  = f;
    r.id    = IdW'(id);
    r.hold  = 1'b0;
    r.quiet = quiet_seq;
    pending.push_back(r);
  endfunction

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // Request driver: offers the pending queue with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        arbitrate(in_flight.func, in_flight.id);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0 && !(pending[0].hold && grant_q.size() > 0)) begin
          in_flight = pending.pop_front();
          quiet_now = in_flight.quiet;
          s_axis_tdata <= {4'b0000, in_flight.id};
          s_axis_tuser <= in_flight.func;
          offer = 1'b1;
          if (!in_flight.quiet && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 9);
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // Result monitor: checks each grant against the oldest one owed.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (grant_q.size() == 0) begin
          $display("%0t: no grant expected, got id %0d tdata %h tuser %b tlast %b", $time,
                   m_axis_tdata[3:0], m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatches++;
        end else begin
          want = grant_q.pop_front();
          check_field("grant_id", int'(want.grant_id), int'(m_axis_tdata[3:0]));
          check_field("readers_active", int'(want.readers_active), int'(m_axis_tdata[8:4]));
          check_field("grant_is_write", int'(want.grant_is_write), int'(m_axis_tuser[0]));
          check_field("refused", int'(want.refused), int'(m_axis_tuser[1]));
          check_field("last", int'(want.last), int'(m_axis_tlast));
          check_field("tdata padding", 0, int'(m_axis_tdata[15:9]));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet_now && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int kind;
    int mark;
    int issued;
    wr_held    = 1'b0;
    rd_count   = '0;
    mismatches = 0;
    gap_left   = 0;
    stall_left = 0;
    quiet_now  = 1'b0;
    quiet_seq  = 1'b0;

    // Stray releases, shared reads, writers waiting on readers and on a writer,
    // a reader burst on write release, and a release with nobody waiting.
    add(FuncEndRead, 0);
    add(FuncEndWrite, 15);
    add(FuncStartRead, 0);
    add(FuncStartRead, 15);
    add(FuncStartWrite, 5);
    add(FuncStartWrite, 10);
    add(FuncEndRead, 0);
    add(FuncEndRead, 15);
    add(FuncStartRead, 3);
    add(FuncStartRead, 12);
    add(FuncEndWrite, 5);
    add(FuncEndRead, 3);
    add(FuncEndRead, 12);
    add(FuncEndWrite, 10);
    add(FuncStartWrite, 15);
    add(FuncStartWrite, 0);
    add(FuncEndWrite, 15);
    add(FuncEndWrite, 0);
    mark = pending.size();

    issued = 0;
    while (issued < 480) begin
      quiet_seq = ($urandom_range(0, 5) == 0);
      kind      = $urandom_range(0, 9);
      issued   -= pending.size();
      case (kind)
        0, 1, 2: begin
          repeat ($urandom_range(8, 16)) add(func_e'($urandom_range(0, 3)), $urandom_range(0, 15));
        end
        3, 4: begin
          // Readers pile up behind a writer; long runs overflow the queue.
          add(FuncStartWrite, $urandom_range(0, 15));
          repeat ($urandom_range(10, 20)) add(FuncStartRead, $urandom_range(0, 15));
          add(FuncEndWrite, $urandom_range(0, 15));
        end
        5, 6: begin
          add(FuncStartRead, $urandom_range(0, 15));
          repeat ($urandom_range(10, 19)) add(FuncStartWrite, $urandom_range(0, 15));
          repeat ($urandom_range(1, 4)) add(FuncEndRead, $urandom_range(0, 15));
          repeat ($urandom_range(1, 3)) add(FuncEndWrite, $urandom_range(0, 15));
        end
        7: begin
          // Long runs of reads that can push the reader count into saturation.
          repeat ($urandom_range(30, 34)) add(FuncStartRead, $urandom_range(0, 15));
        end
        default: begin
          repeat ($urandom_range(5, 35)) add(FuncEndRead, $urandom_range(0, 15));
          repeat ($urandom_range(1, 3)) add(FuncEndWrite, $urandom_range(0, 15));
        end
      endcase
      issued += pending.size();
    end
    pending[mark].hold = 1'b1;
    pending[pending.size() / 2].hold = 1'b1;
    for (int i = pending.size() - 60; i < pending.size(); i++) pending[i].quiet = 1'b1;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || s_axis_tvalid || grant_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[reader_writer_lock_arbiter] OK");
    end else begin
      $display("[reader_writer_lock_arbiter] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[reader_writer_lock_arbiter] ERROR");
    $finish;
  end

endmodule
